>>> design/mhak_pkg.sv
// Shared constants, codes and types for the max-heap alter-key block.
package mhak_pkg;

    // Store geometry and field widths.
    localparam int DEPTH = 64;
    localparam int IDX_W = 6;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CH_W  = IDX_W + 2;
    localparam int KEY_W = 32;

    // Operation codes carried on the op field.
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_ALTER = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_BLD_RD,
        S_BLD_LD,
        S_UP_CHK,
        S_DN_CHK,
        S_DONE
    } state_t;

    // Decision of the shared compare unit.
    typedef struct packed {
        logic move;
        logic take_b;
    } pick_t;

endpackage

>>> design/mhak_ram.sv
// Key store: one write port and two registered read ports.
module mhak_ram #(
    parameter int DEPTH_P = 64,
    parameter int WIDTH_P = 32,
    localparam int AW = $clog2(DEPTH_P)
) (
    input  logic               clk,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  logic [WIDTH_P-1:0] wdata,
    input  logic               re,
    input  logic [AW-1:0]      raddr_a,
    input  logic [AW-1:0]      raddr_b,
    output logic [WIDTH_P-1:0] rdata_a,
    output logic [WIDTH_P-1:0] rdata_b
);

    logic [WIDTH_P-1:0] mem [DEPTH_P];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read ports; data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

>>> design/mhak_pick.sv
// Shared compare unit: decides whether the moving key trades places with a neighbor.
module mhak_pick (
    input  logic signed [mhak_pkg::KEY_W-1:0] cur,
    input  logic        [mhak_pkg::KEY_W-1:0] a,
    input  logic        [mhak_pkg::KEY_W-1:0] b,
    input  logic                              a_ok,
    input  logic                              b_ok,
    input  logic                              up,
    output mhak_pkg::pick_t                   pick
);
    import mhak_pkg::*;

    logic                    a_win;
    logic                    b_win;
    logic signed [KEY_W-1:0] best;

    // Rising, the moving key must strictly beat its parent. Sinking, the left child
    // wins on strictly greater and the right one must beat the better of the two.
    always_comb
    begin
        a_win       = a_ok && (up ? ($signed(a) < cur) : (cur < $signed(a)));
        best        = a_win ? $signed(a) : cur;
        b_win       = b_ok && (best < $signed(b));
        pick.move   = a_win || b_win;
        pick.take_b = b_win;
    end

endmodule

>>> design/max_heap_alter_key.sv
// Top level of the max-heap alter-key block: sequencer, state and result register.
//
// Input channel (in_valid / in_stall) carries op, index, value and last; a transfer
// happens on a rising edge with in_valid high and in_stall low. The output channel
// (out_valid / out_stall) returns one result per input: read_value, root_value,
// final_index and error. in_stall is high whenever the sequencer is busy.
// Every sift step goes through the single key store and one shared compare unit:
// each heap level waits on the store's registered read before its compare.
// A read, a load without last and every error case go straight to the completion
// state. An alter first tries to rise level by level and, if it does not rise,
// sinks level by level. A load with last builds the heap by sifting up each entry
// from 1 to n-1 in turn, reading each one from the store first.
// The next input is taken in the cycle after the result is loaded into the output
// register, even while that result is still stalled. If the receiver stalls, a
// finished result waits in the sequencer until the output register frees up.
// Reset clears the heap size and empties the output register; the key store
// keeps no reset value and needs no clearing pass.
module max_heap_alter_key (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          op,
    input  logic [mhak_pkg::IDX_W-1:0]          index,
    input  logic signed [mhak_pkg::KEY_W-1:0]   value,
    input  logic                                last,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [mhak_pkg::KEY_W-1:0]   read_value,
    output logic signed [mhak_pkg::KEY_W-1:0]   root_value,
    output logic [mhak_pkg::IDX_W-1:0]          final_index,
    output logic                                error
);
    import mhak_pkg::*;

    // Control registers.
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              first_reg, first_next;
    logic              build_reg, build_next;
    logic              out_valid_reg, out_valid_next;

    // Payload registers.
    logic [1:0]              op_reg, op_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic                    err_reg, err_next;
    logic [IDX_W-1:0]        pos_reg, pos_next;
    logic [IDX_W-1:0]        e_reg, e_next;
    logic signed [KEY_W-1:0] cur_reg, cur_next;
    logic signed [KEY_W-1:0] root_reg;
    logic signed [KEY_W-1:0] rd_out_reg, rd_out_next;
    logic signed [KEY_W-1:0] root_out_reg, root_out_next;
    logic [IDX_W-1:0]        fin_out_reg, fin_out_next;
    logic                    err_out_reg, err_out_next;

    // Store ports.
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [KEY_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr_a;
    logic [IDX_W-1:0] raddr_b;
    logic [KEY_W-1:0] rdata_a;
    logic [KEY_W-1:0] rdata_b;

    // Compare unit hookup.
    logic  a_ok;
    logic  b_ok;
    logic  up_dir;
    pick_t pk;

    // Helpers for the sift steps.
    logic             in_xfer;
    logic [CH_W-1:0]  left_w;
    logic [CH_W-1:0]  right_w;
    logic [IDX_W-1:0] chosen_w;
    logic [CH_W-1:0]  cleft_w;
    logic [IDX_W-1:0] up_w;
    logic [IDX_W-1:0] e_inc_w;
    logic             out_free;

    function automatic logic [IDX_W-1:0] parent_of(input logic [IDX_W-1:0] p);
        return (p - 1'b1) >> 1;
    endfunction

    function automatic logic [CH_W-1:0] left_of(input logic [IDX_W-1:0] p);
        return {1'b0, p, 1'b1};
    endfunction

    mhak_ram #(
        .DEPTH_P (DEPTH),
        .WIDTH_P (KEY_W)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .re      (re),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    mhak_pick u_pick (
        .cur  (cur_reg),
        .a    (rdata_a),
        .b    (rdata_b),
        .a_ok (a_ok),
        .b_ok (b_ok),
        .up   (up_dir),
        .pick (pk)
    );

    assign in_stall    = (state_reg != S_IDLE);
    assign in_xfer     = in_valid && !in_stall;
    assign out_valid   = out_valid_reg;
    assign read_value  = rd_out_reg;
    assign root_value  = root_out_reg;
    assign final_index = fin_out_reg;
    assign error       = err_out_reg;
    assign out_free    = !out_valid_reg || !out_stall;
    assign up_dir      = (state_reg == S_UP_CHK);

    // Neighbor positions of the moving key.
    always_comb
    begin
        left_w   = left_of(pos_reg);
        right_w  = left_w + CH_W'(1);
        chosen_w = pk.take_b ? right_w[IDX_W-1:0] : left_w[IDX_W-1:0];
        cleft_w  = left_of(chosen_w);
        up_w     = parent_of(pos_reg);
        e_inc_w  = e_reg + 1'b1;
    end

    // Sequencer: next state, store access and result capture.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        first_next     = first_reg;
        build_next     = build_reg;
        op_next        = op_reg;
        idx_next       = idx_reg;
        err_next       = err_reg;
        pos_next       = pos_reg;
        e_next         = e_reg;
        cur_next       = cur_reg;
        rd_out_next    = rd_out_reg;
        root_out_next  = root_out_reg;
        fin_out_next   = fin_out_reg;
        err_out_next   = err_out_reg;
        out_valid_next = out_valid_reg && out_stall;
        we             = 1'b0;
        waddr          = pos_reg;
        wdata          = cur_reg;
        re             = 1'b0;
        raddr_a        = up_w;
        raddr_b        = up_w;
        a_ok           = 1'b0;
        b_ok           = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    op_next    = op;
                    idx_next   = index;
                    state_next = S_DONE;
                    priority if (op == OP_LOAD)
                    begin
                        err_next = ({1'b0, index} >= CNT_W'(DEPTH));
                        if (!err_next)
                        begin
                            we    = 1'b1;
                            waddr = index;
                            wdata = value;
                            if (last)
                            begin
                                count_next = {1'b0, index} + CNT_W'(1);
                                build_next = 1'b1;
                                e_next     = IDX_W'(1);
                                if (index != '0)
                                begin
                                    state_next = S_BLD_RD;
                                end
                            end
                        end
                    end
                    else if (op == OP_ALTER)
                    begin
                        err_next = ({1'b0, index} >= count_reg);
                        if (!err_next)
                        begin
                            cur_next   = value;
                            pos_next   = index;
                            first_next = 1'b1;
                            build_next = 1'b0;
                            re         = 1'b1;
                            raddr_a    = parent_of(index);
                            state_next = S_UP_CHK;
                        end
                    end
                    else if (op == OP_READ)
                    begin
                        err_next = ({1'b0, index} >= count_reg);
                        re       = 1'b1;
                        raddr_a  = index;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
            end

            S_BLD_RD:
            begin
                re         = 1'b1;
                raddr_a    = e_reg;
                state_next = S_BLD_LD;
            end

            S_BLD_LD:
            begin
                cur_next   = $signed(rdata_a);
                pos_next   = e_reg;
                first_next = 1'b0;
                re         = 1'b1;
                raddr_a    = parent_of(e_reg);
                state_next = S_UP_CHK;
            end

            S_UP_CHK:
            begin
                a_ok = (pos_reg != '0);
                if (pk.move)
                begin
                    // Parent moves down into the hole; keep climbing.
                    we         = 1'b1;
                    wdata      = rdata_a;
                    pos_next   = up_w;
                    first_next = 1'b0;
                    re         = 1'b1;
                    raddr_a    = parent_of(up_w);
                end
                else if (first_reg)
                begin
                    // Altered key does not rise: fetch both children and sink.
                    first_next = 1'b0;
                    re         = 1'b1;
                    raddr_a    = left_w[IDX_W-1:0];
                    raddr_b    = right_w[IDX_W-1:0];
                    state_next = S_DN_CHK;
                end
                else
                begin
                    we = 1'b1;
                    if (build_reg && ({1'b0, e_inc_w} < count_reg) && (e_inc_w != '0))
                    begin
                        e_next     = e_inc_w;
                        re         = 1'b1;
                        raddr_a    = e_inc_w;
                        state_next = S_BLD_LD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_DN_CHK:
            begin
                a_ok = (left_w < CH_W'(count_reg));
                b_ok = (right_w < CH_W'(count_reg));
                if (pk.move)
                begin
                    // Larger child moves up into the hole; keep sinking.
                    we       = 1'b1;
                    wdata    = pk.take_b ? rdata_b : rdata_a;
                    pos_next = chosen_w;
                    re       = 1'b1;
                    raddr_a  = cleft_w[IDX_W-1:0];
                    raddr_b  = cleft_w[IDX_W-1:0] + 1'b1;
                end
                else
                begin
                    we         = 1'b1;
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    rd_out_next    = (op_reg == OP_READ && !err_reg) ? $signed(rdata_a) : '0;
                    root_out_next  = (count_reg != '0) ? root_reg : '0;
                    fin_out_next   = (op_reg == OP_ALTER && !err_reg) ? pos_reg : idx_reg;
                    err_out_next   = err_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            first_reg     <= 1'b0;
            build_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            first_reg     <= first_next;
            build_reg     <= build_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload state; the root copy follows every write to position zero.
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        idx_reg      <= idx_next;
        err_reg      <= err_next;
        pos_reg      <= pos_next;
        e_reg        <= e_next;
        cur_reg      <= cur_next;
        rd_out_reg   <= rd_out_next;
        root_out_reg <= root_out_next;
        fin_out_reg  <= fin_out_next;
        err_out_reg  <= err_out_next;
        if (we && waddr == '0)
        begin
            root_reg <= $signed(wdata);
        end
    end

    // The heap size never exceeds the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
    else $error("heap size beyond store depth");

    // A sifting key always sits inside the heap.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UP_CHK || state_reg == S_DN_CHK) |-> ({1'b0, pos_reg} < count_reg))
    else $error("sift position outside heap");

    // A rise step moves toward the root, a sink step away from it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UP_CHK && pk.move) |=> (pos_reg < $past(pos_reg)))
    else $error("rise step did not move up");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DN_CHK && pk.move) |=> (pos_reg > $past(pos_reg)))
    else $error("sink step did not move down");

    // A new result appears only from the completion state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg || !out_stall) && out_valid_next |-> (state_reg == S_DONE))
    else $error("result loaded outside completion");

endmodule

>>> tb/mhak_checker.sv
// Checker for the max-heap alter-key block: predicts each result and compares it.
`timescale 1ns / 1ps

module mhak_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic [1:0]                          op,
    input  logic [mhak_pkg::IDX_W-1:0]          index,
    input  logic signed [mhak_pkg::KEY_W-1:0]   value,
    input  logic                                last,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic signed [mhak_pkg::KEY_W-1:0]   read_value,
    input  logic signed [mhak_pkg::KEY_W-1:0]   root_value,
    input  logic [mhak_pkg::IDX_W-1:0]          final_index,
    input  logic                                error,
    output int                                  mismatches,
    output int                                  outstanding,
    output int                                  results_seen
);
    import mhak_pkg::*;

    // One predicted result, with the request that caused it kept for messages.
    typedef struct {
        logic [1:0]              code;
        logic [IDX_W-1:0]        idx;
        logic signed [KEY_W-1:0] read_value;
        logic signed [KEY_W-1:0] root_value;
        logic [IDX_W-1:0]        final_index;
        logic                    error;
    } heap_outcome_t;

    // Shadow copy of the heap array and its size.
    logic signed [KEY_W-1:0] keys [DEPTH];
    logic [CNT_W-1:0]        heap_size;
    heap_outcome_t           heap_outcomes [$];
    heap_outcome_t           want;

    // Move the key at pos toward the root while it beats its parent.
    function automatic int unsigned sift_up(int unsigned pos);
        int unsigned             parent;
        logic signed [KEY_W-1:0] held;
        while (pos > 0)
        begin
            parent = (pos - 1) / 2;
            if (!(keys[parent] < keys[pos]))
                break;
            held = keys[parent];
            keys[parent] = keys[pos];
            keys[pos] = held;
            pos = parent;
        end
        return pos;
    endfunction

    // Move the key at pos toward the leaves while a present child beats it.
    // On equal children the left one wins.
    function automatic int unsigned sift_down(int unsigned pos);
        int unsigned             left;
        int unsigned             right;
        int unsigned             pick;
        logic signed [KEY_W-1:0] held;
        forever
        begin
            left = 2 * pos + 1;
            right = left + 1;
            pick = pos;
            if (left >= heap_size)
                break;
            if (keys[pick] < keys[left])
                pick = left;
            if (right < heap_size && keys[pick] < keys[right])
                pick = right;
            if (pick == pos)
                break;
            held = keys[pos];
            keys[pos] = keys[pick];
            keys[pick] = held;
            pos = pick;
        end
        return pos;
    endfunction

    // Apply one request to the shadow heap and return the result it gives.
    function automatic heap_outcome_t heap_apply(logic [1:0] code, logic [IDX_W-1:0] idx,
                                                 logic signed [KEY_W-1:0] key, logic closes);
        heap_outcome_t r;
        int unsigned   e;
        r.code = code;
        r.idx = idx;
        r.read_value = '0;
        r.final_index = idx;
        r.error = 1'b0;
        case (code)
            OP_LOAD:
            begin
                if (idx < DEPTH)
                begin
                    keys[idx] = key;
                    if (closes)
                    begin
                        heap_size = CNT_W'(idx) + 1'b1;
                        for (e = 1; e < heap_size; e++)
                            void'(sift_up(e));
                    end
                end
                else
                    r.error = 1'b1;
            end
            OP_ALTER:
            begin
                if (idx < heap_size)
                begin
                    keys[idx] = key;
                    if (idx > 0 && keys[(idx - 1) / 2] < key)
                        r.final_index = IDX_W'(sift_up(idx));
                    else
                        r.final_index = IDX_W'(sift_down(idx));
                end
                else
                    r.error = 1'b1;
            end
            OP_READ:
            begin
                if (idx < heap_size)
                    r.read_value = keys[idx];
                else
                    r.error = 1'b1;
            end
            default:
                r.error = 1'b1;
        endcase
        r.root_value = (heap_size > 0) ? keys[0] : '0;
        return r;
    endfunction

    // Print one line per mismatch (the first few) and count them all.
    task automatic report_mismatch(input string what);
        if (mismatches < 30)
            $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Compare each result transfer with the oldest prediction, then predict
    // for an input transfer on the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_outcomes.delete();
            heap_size = '0;
            foreach (keys[i])
                keys[i] = '0;
            mismatches = 0;
            results_seen = 0;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (heap_outcomes.size() == 0)
                    report_mismatch("result arrived with no request waiting");
                else
                begin
                    want = heap_outcomes.pop_front();
                    if (read_value !== want.read_value)
                        report_mismatch($sformatf("op %0d index %0d: read_value %0d, want %0d",
                            want.code, want.idx, read_value, want.read_value));
                    if (root_value !== want.root_value)
                        report_mismatch($sformatf("op %0d index %0d: root_value %0d, want %0d",
                            want.code, want.idx, root_value, want.root_value));
                    if (final_index !== want.final_index)
                        report_mismatch($sformatf("op %0d index %0d: final_index %0d, want %0d",
                            want.code, want.idx, final_index, want.final_index));
                    if (error !== want.error)
                        report_mismatch($sformatf("op %0d index %0d: error %0b, want %0b",
                            want.code, want.idx, error, want.error));
                end
            end
            if (in_valid && !in_stall)
                heap_outcomes.push_back(heap_apply(op, index, value, last));
            outstanding <= heap_outcomes.size();
        end
    end

endmodule

>>> tb/testbench.sv
// Top of the max-heap alter-key testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
    import mhak_pkg::*;

    // The op field can carry a code that names no operation.
    localparam logic [1:0] OP_UNKNOWN = 2'd3;
    localparam int RANDOM_ITEMS = 400;
    localparam int QUIET_LIMIT = 4000;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [1:0]              op;
    logic [IDX_W-1:0]        index;
    logic signed [KEY_W-1:0] value;
    logic                    last;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [KEY_W-1:0] read_value;
    logic signed [KEY_W-1:0] root_value;
    logic [IDX_W-1:0]        final_index;
    logic                    error;

    int mismatches;
    int outstanding;
    int results_seen;

    // Sender bookkeeping: which entries hold a key and how big the heap is.
    logic [DEPTH-1:0] loaded;
    logic [DEPTH-1:0] span_mask;
    int unsigned      live_size;
    int               burst_left;
    int               items_sent;
    int               first_random;
    int               load_count;
    int               alter_count;
    int               read_count;
    int               unknown_count;
    int               build_count;
    int               largest_build;
    int               quiet_cycles;
    int               n;
    int               k;
    int               sel;
    bit               paused;
    logic [IDX_W-1:0] idx;
    logic [4:0]       stall_phase;
    logic [1:0]       stall_mode;

    max_heap_alter_key dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .index       (index),
        .value       (value),
        .last        (last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_value  (read_value),
        .root_value  (root_value),
        .final_index (final_index),
        .error       (error)
    );

    mhak_checker heap_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .index        (index),
        .value        (value),
        .last         (last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .read_value   (read_value),
        .root_value   (root_value),
        .final_index  (final_index),
        .error        (error),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .results_seen (results_seen)
    );

    // Clock with a 4 ns period.
    always #2 clk = ~clk;

    // The receiver switches among four stall patterns, drawing a new one whenever the stall phase wraps.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            stall_phase <= '0;
            stall_mode <= '0;
            out_stall <= 1'b0;
        end
        else
        begin
            stall_phase <= stall_phase + 1'b1;
            if (stall_phase == '0)
                stall_mode <= 2'($urandom_range(0, 3));
            case (stall_mode)
                2'd0: out_stall <= 1'b0;
                2'd1: out_stall <= ($urandom_range(0, 3) == 0);
                2'd2: out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= ~out_stall;
            endcase
        end
    end

    // Watchdog: end the run if no transfer happens on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t ns: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Draw a key: full range, clustered small values for ties, or an extreme.
    function automatic logic signed [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 4))
            0: return KEY_W'($urandom_range(0, 6)) - KEY_W'(3);
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return -32'sd1;
                    default: return '0;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // Present one request, hold it until its transfer, then maybe open a gap.
    task automatic send_item(input logic [1:0] code, input logic [IDX_W-1:0] at,
                             input logic signed [KEY_W-1:0] key, input logic closes);
        logic taken;
        in_valid <= 1'b1;
        op <= code;
        index <= at;
        value <= key;
        last <= closes;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        items_sent++;
        case (code)
            OP_LOAD:
            begin
                load_count++;
                loaded[at] = 1'b1;
                if (closes)
                begin
                    live_size = at + 1;
                    build_count++;
                    if (at + 1 > largest_build)
                        largest_build = at + 1;
                end
            end
            OP_ALTER: alter_count++;
            OP_READ: read_count++;
            default: unknown_count++;
        endcase
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        else
            burst_left--;
    endtask

    // Hold off the sender until every predicted result has been returned.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        @(posedge clk);
    endtask

    // Stimulus: directed cases first, then random heap sessions and noise.
    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        op <= OP_READ;
        index <= '0;
        value <= '0;
        last <= 1'b0;
        loaded = '0;
        live_size = 0;
        burst_left = 3;
        items_sent = 0;
        load_count = 0;
        alter_count = 0;
        read_count = 0;
        unknown_count = 0;
        build_count = 0;
        largest_build = 0;
        paused = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty heap: read and alter are out of range; the unknown code errors.
        send_item(OP_READ, 6'd0, '0, 1'b0);
        send_item(OP_ALTER, 6'd0, 32'sd9, 1'b1);
        send_item(OP_UNKNOWN, 6'd63, 32'sh7fff_ffff, 1'b1);

        // Build a seven-entry heap with extremes and equal keys.
        send_item(OP_LOAD, 6'd0, 32'sh8000_0000, 1'b0);
        send_item(OP_LOAD, 6'd1, 32'sd5, 1'b0);
        send_item(OP_LOAD, 6'd2, 32'sh7fff_ffff, 1'b0);
        send_item(OP_LOAD, 6'd3, -32'sd1, 1'b0);
        send_item(OP_LOAD, 6'd4, 32'sd5, 1'b0);
        send_item(OP_LOAD, 6'd5, 32'sd0, 1'b0);
        send_item(OP_LOAD, 6'd6, 32'sd5, 1'b1);

        // Reads inside and past the heap.
        send_item(OP_READ, 6'd0, '0, 1'b0);
        send_item(OP_READ, 6'd6, '0, 1'b0);
        send_item(OP_READ, 6'd7, '0, 1'b0);
        send_item(OP_READ, 6'd63, '1, 1'b1);

        // Alters: rise to a tie with the root, sink from the root down to a leaf,
        // a leaf with no children, and one past the heap.
        send_item(OP_ALTER, 6'd6, 32'sh7fff_ffff, 1'b0);
        send_item(OP_ALTER, 6'd0, 32'sh8000_0000, 1'b0);
        send_item(OP_ALTER, 6'd3, 32'sh8000_0000, 1'b0);
        send_item(OP_ALTER, 6'd63, 32'sd1, 1'b0);

        // A load past the heap that does not close it, then a one-entry heap.
        send_item(OP_LOAD, 6'd63, 32'sd77, 1'b0);
        send_item(OP_LOAD, 6'd0, -32'sd3, 1'b1);
        send_item(OP_ALTER, 6'd0, 32'sd12, 1'b0);
        send_item(OP_READ, 6'd1, '0, 1'b0);
        drain_results();

        // Random part: mostly complete heap sessions, some noise.
        first_random = items_sent;
        while (items_sent - first_random < RANDOM_ITEMS)
        begin
            if (!paused && items_sent - first_random >= RANDOM_ITEMS / 2)
            begin
                paused = 1'b1;
                drain_results();
            end
            sel = $urandom_range(0, 9);
            if (sel <= 6)
            begin
                // Load a fresh heap, mostly small, then alter and read it.
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(33, DEPTH)
                                                : $urandom_range(1, 12);
                for (k = 0; k < n; k++)
                    send_item(OP_LOAD, IDX_W'(k), pick_key(), k == n - 1);
                repeat ($urandom_range(3, 10))
                begin
                    if (live_size < DEPTH && $urandom_range(0, 7) == 0)
                        idx = IDX_W'($urandom_range(live_size, DEPTH - 1));
                    else
                        idx = IDX_W'($urandom_range(0, live_size - 1));
                    send_item(($urandom_range(0, 4) < 3) ? OP_ALTER : OP_READ, idx,
                              pick_key(), 1'($urandom_range(0, 1)));
                end
            end
            else if (sel == 7)
            begin
                // Noise: an unknown code, or a stray load that leaves the size alone.
                if ($urandom_range(0, 1) == 0)
                    send_item(OP_UNKNOWN, IDX_W'($urandom), $urandom, 1'($urandom));
                else
                    send_item(OP_LOAD, IDX_W'($urandom), pick_key(), 1'b0);
            end
            else if (sel == 8)
            begin
                // Alter or read anywhere in the store, in range or not.
                send_item(($urandom_range(0, 1) == 0) ? OP_ALTER : OP_READ,
                          IDX_W'($urandom), pick_key(), 1'($urandom));
            end
            else
            begin
                // A load that closes the heap only where every entry up to it holds a key.
                idx = IDX_W'($urandom);
                span_mask = ({{(DEPTH-1){1'b0}}, 1'b1} << (idx + 1)) - 1'b1;
                send_item(OP_LOAD, idx, pick_key(), (loaded & span_mask) == span_mask);
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        $display("Sent %0d requests: %0d loads (%0d heap builds, largest %0d entries),",
                 items_sent, load_count, build_count, largest_build);
        $display("%0d alters, %0d reads, %0d unknown codes; %0d results checked.",
                 alter_count, read_count, unknown_count, results_seen);
        if (mismatches == 0 && outstanding == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
